>>> hw/rtl/brr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_pkg
// Shared constants, command codes and word types of the bit reservoir reader.
// ----------------------------------------------------------------------------
package brr_pkg;

    // reservoir store, split into four byte banks so a 32-bit window is one read per bank
    localparam int STORE_DEPTH   = 4096;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int BANKS         = 4;
    localparam int BANK_SEL_W    = $clog2(BANKS);
    localparam int ROWS          = STORE_DEPTH / BANKS;
    localparam int ROW_AW        = STORE_AW - BANK_SEL_W;

    localparam int MAX_READ_BITS = 25;
    localparam int READ_N_W      = $clog2(MAX_READ_BITS + 1);

    localparam int POS_W         = 16;
    localparam int BITPOS_W      = 19;
    localparam int CNT_W         = 15;
    localparam int BACK_W        = 12;
    localparam int BYTE_W        = 8;
    localparam int VALUE_W       = 25;
    localparam int WORD_W        = 32;
    localparam int SHIFT_W       = $clog2(WORD_W) + 1;

    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_AW       = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_LVL_W    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH    = 4;
    localparam int RESQ_AW       = $clog2(RESQ_DEPTH);
    localparam int RESQ_LVL_W    = $clog2(RESQ_DEPTH + 1);

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_BEGIN  = 3'd2;
    localparam logic [2:0] CMD_GET    = 3'd3;
    localparam logic [2:0] CMD_PEEK   = 3'd4;
    localparam logic [2:0] CMD_SKIP   = 3'd5;
    localparam logic [2:0] CMD_MARK   = 3'd6;
    localparam logic [2:0] CMD_SEEK   = 3'd7;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  bit_count;
        logic [BACK_W-1:0] back_offset;
    } brr_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
        logic               overrun;
        logic [CNT_W-1:0]   bits_since_mark;
    } brr_out_t;

    // decoded command word handed from the front end to the executor
    typedef struct packed {
        logic              is_clear;
        logic              is_append;
        logic              is_begin;
        logic              is_read;
        logic              is_get;
        logic              is_skip;
        logic              is_mark;
        logic              is_seek;
        logic              too_long;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  bit_count;
        logic [BACK_W-1:0] back_offset;
    } brr_cmd_t;

endpackage

>>> hw/rtl/bit_reservoir_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_reservoir_reader
// MSB-first bit reader over a byte ring that serves as a bit reservoir.
// ----------------------------------------------------------------------------
// The block takes one command word per clock while it is not full, and returns
// one result word per command, in order. A pushed word passes the command queue,
// the state update with the store read, and bit extraction into the result queue
// before its result can be popped. The sustained rate is one word per cycle while
// the result queue has room: the read position updates once per word, and the
// 32-bit window under it comes from four byte banks with one read port each, so
// every window is one read per bank. Both sides are queues, so pushing continues
// while results wait to be popped, until the queues fill.
// Store entries are not cleared at reset; a byte that was never appended is
// only read as zero where it lies at or past the write end.
module bit_reservoir_reader (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  brr_pkg::brr_in_t  item,
    output logic              empty,
    input  logic              pop,
    output brr_pkg::brr_out_t result
);
    import brr_pkg::*;

    logic                  cmd_valid;
    brr_cmd_t              cmd;
    logic                  take;
    logic [RESQ_LVL_W-1:0] res_level;
    logic                  res_valid;
    brr_out_t              res;

    brr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .take      (take)
    );

    brr_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .take      (take),
        .res_level (res_level),
        .res_valid (res_valid),
        .res       (res)
    );

    brr_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .level    (res_level),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // a word leaving the executor always finds a free slot in the result queue
    a_resq_room : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_level < RESQ_LVL_W'(RESQ_DEPTH)))
        else $error("result queue overflow");

    // an issued command reaches the extraction stage on the next cycle
    a_issue_flow : assert property (@(posedge clk) disable iff (!rst_n)
        take |=> res_valid)
        else $error("issued command lost before extraction");

    // a full command queue always presents a word to the executor
    a_front_head : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cmd_valid)
        else $error("command queue full but head not valid");

endmodule

>>> hw/rtl/brr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_front
// Accepts input words, decodes the command and queues the decoded word.
// ----------------------------------------------------------------------------
module brr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  brr_pkg::brr_in_t  item,
    output logic              cmd_valid,
    output brr_pkg::brr_cmd_t cmd,
    input  logic              take
);
    import brr_pkg::*;

    brr_cmd_t              dec;
    brr_cmd_t              q_mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_LVL_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    always_comb
    begin
        dec             = '0;
        dec.data_byte   = item.data_byte;
        dec.bit_count   = item.bit_count;
        dec.back_offset = item.back_offset;
        dec.too_long    = (item.bit_count > CNT_W'(MAX_READ_BITS));
        case (item.cmd)
            CMD_CLEAR:  dec.is_clear  = 1'b1;
            CMD_APPEND: dec.is_append = 1'b1;
            CMD_BEGIN:  dec.is_begin  = 1'b1;
            CMD_GET:
            begin
                dec.is_read = 1'b1;
                dec.is_get  = 1'b1;
            end
            CMD_PEEK:   dec.is_read   = 1'b1;
            CMD_SKIP:   dec.is_skip   = 1'b1;
            CMD_MARK:   dec.is_mark   = 1'b1;
            CMD_SEEK:   dec.is_seek   = 1'b1;
            default:    dec.is_clear  = 1'b1;
        endcase
    end

    assign full      = (count_reg == CMDQ_LVL_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? CMDQ_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? CMDQ_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = CMDQ_LVL_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CMDQ_LVL_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem_reg[wr_ptr_reg] <= dec;
    end

endmodule

>>> hw/rtl/brr_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_exec
// Executes decoded commands: position state, banked byte store, bit extract.
// ----------------------------------------------------------------------------
module brr_exec (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  brr_pkg::brr_cmd_t                  cmd,
    output logic                               take,
    input  logic [brr_pkg::RESQ_LVL_W-1:0]     res_level,
    output logic                               res_valid,
    output brr_pkg::brr_out_t                  res
);
    import brr_pkg::*;

    typedef struct packed {
        logic                  read_en;
        logic                  ok;
        logic [BANKS-1:0]      byte_ok;
        logic [BANK_SEL_W-1:0] lo;
        logic [2:0]            bit_sh;
        logic [READ_N_W-1:0]   n;
        logic [BITPOS_W-1:0]   pos;
        logic [BITPOS_W-1:0]   mark;
        logic [POS_W-1:0]      wt;
        logic                  wrapped;
    } brr_s2_t;

    localparam logic [POS_W:0] DEPTH_LIM = (POS_W + 1)'(STORE_DEPTH);

    logic [POS_W-1:0]    wt_reg, wt_next;
    logic [POS_W-1:0]    rbyte_reg, rbyte_next;
    logic [2:0]          rbit_reg, rbit_next;
    logic [BITPOS_W-1:0] mark_reg, mark_next;
    logic                wrapped_reg, wrapped_next;
    logic                s2_valid_reg;
    brr_s2_t             s2_reg, s2_next;

    logic [BITPOS_W-1:0] cur_pos;
    logic [BITPOS_W-1:0] base_pos;
    logic [BITPOS_W-1:0] sum_pos;
    logic                ok_s1;
    logic                wr_en;
    logic [BANKS-1:0]    byte_ok;
    logic [ROW_AW-1:0]   rd_row [BANKS];
    logic [BYTE_W-1:0]   bank_rd_reg [BANKS];
    logic                room;

    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   word_sh;
    logic [WORD_W-1:0]   extract;
    logic [SHIFT_W-1:0]  rsh;
    logic [POS_W-1:0]    end_dist;
    logic                at_end;
    logic [BITPOS_W:0]   since;

    // keep a slot in the result queue for every word in flight
    assign room = ((RESQ_LVL_W + 1)'(res_level) + (RESQ_LVL_W + 1)'(s2_valid_reg))
                  < (RESQ_LVL_W + 1)'(RESQ_DEPTH);
    assign take = cmd_valid && room;

    assign cur_pos  = {rbyte_reg, rbit_reg};
    assign base_pos = cmd.is_seek ? mark_reg : cur_pos;
    assign sum_pos  = BITPOS_W'(base_pos + BITPOS_W'(cmd.bit_count));
    assign wr_en    = take && cmd.is_append;

    always_comb
    begin
        wt_next      = wt_reg;
        rbyte_next   = rbyte_reg;
        rbit_next    = rbit_reg;
        mark_next    = mark_reg;
        wrapped_next = wrapped_reg;
        ok_s1        = 1'b1;
        if (cmd.is_clear)
        begin
            wt_next      = '0;
            rbyte_next   = '0;
            rbit_next    = '0;
            wrapped_next = 1'b0;
        end
        else if (cmd.is_append)
        begin
            wt_next = POS_W'(wt_reg + 1'b1);
            if (wt_reg == '1)
                wrapped_next = 1'b1;
        end
        else if (cmd.is_begin)
        begin
            // first frame: not enough bytes behind the write end yet
            if (!wrapped_reg && (POS_W'(cmd.back_offset) > wt_reg))
                ok_s1 = 1'b0;
            else
            begin
                rbyte_next = POS_W'(wt_reg - POS_W'(cmd.back_offset));
                rbit_next  = '0;
            end
        end
        else if (cmd.is_read)
        begin
            if (cmd.too_long)
                ok_s1 = 1'b0;
            else if (cmd.is_get)
                {rbyte_next, rbit_next} = sum_pos;
        end
        else if (cmd.is_skip || cmd.is_seek)
            {rbyte_next, rbit_next} = sum_pos;
        else if (cmd.is_mark)
            mark_next = cur_pos;
    end

    // validity of the four window bytes against the write end
    always_comb
    begin
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] d;
        for (int k = 0; k < BANKS; k++)
        begin
            p = POS_W'(rbyte_reg + POS_W'(k));
            d = POS_W'(wt_reg - p);
            if (wrapped_reg)
                byte_ok[k] = (d != '0) && ({1'b0, d} <= DEPTH_LIM);
            else
                byte_ok[k] = (p < wt_reg) && ({1'b0, d} <= DEPTH_LIM);
        end
    end

    // each bank holds one byte of the window, at the row of its own position
    always_comb
    begin
        logic [BANK_SEL_W-1:0] off;
        logic [POS_W-1:0]      p;
        for (int b = 0; b < BANKS; b++)
        begin
            off       = BANK_SEL_W'(BANK_SEL_W'(b) - rbyte_reg[BANK_SEL_W-1:0]);
            p         = POS_W'(rbyte_reg + POS_W'(off));
            rd_row[b] = p[STORE_AW-1:BANK_SEL_W];
        end
    end

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [BYTE_W-1:0] mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wt_reg[BANK_SEL_W-1:0] == BANK_SEL_W'(b)))
                mem[wt_reg[STORE_AW-1:BANK_SEL_W]] <= cmd.data_byte;
            if (take)
                bank_rd_reg[b] <= mem[rd_row[b]];
        end
    end

    always_comb
    begin
        s2_next         = '0;
        s2_next.read_en = cmd.is_read && !cmd.too_long && (cmd.bit_count != '0);
        s2_next.ok      = ok_s1;
        s2_next.byte_ok = byte_ok;
        s2_next.lo      = rbyte_reg[BANK_SEL_W-1:0];
        s2_next.bit_sh  = rbit_reg;
        s2_next.n       = cmd.bit_count[READ_N_W-1:0];
        s2_next.pos     = {rbyte_next, rbit_next};
        s2_next.mark    = mark_next;
        s2_next.wt      = wt_next;
        s2_next.wrapped = wrapped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg       <= '0;
            rbyte_reg    <= '0;
            rbit_reg     <= '0;
            mark_reg     <= '0;
            wrapped_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= take;
            if (take)
            begin
                wt_reg      <= wt_next;
                rbyte_reg   <= rbyte_next;
                rbit_reg    <= rbit_next;
                mark_reg    <= mark_next;
                wrapped_reg <= wrapped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s2_reg <= s2_next;
    end

    // second stage: assemble the window msb first and pull the field out
    always_comb
    begin
        logic [BANK_SEL_W-1:0] idx;
        word = '0;
        for (int k = 0; k < BANKS; k++)
        begin
            idx = BANK_SEL_W'(s2_reg.lo + BANK_SEL_W'(k));
            if (s2_reg.byte_ok[k])
                word[WORD_W-1-BYTE_W*k -: BYTE_W] = bank_rd_reg[idx];
        end
    end

    assign word_sh = word << s2_reg.bit_sh;
    assign rsh     = SHIFT_W'(SHIFT_W'(WORD_W) - SHIFT_W'(s2_reg.n));
    assign extract = word_sh >> rsh;

    assign end_dist = POS_W'(s2_reg.wt - s2_reg.pos[BITPOS_W-1:3]);
    assign at_end   = s2_reg.wrapped ? ((end_dist == '0) || end_dist[POS_W-1])
                                     : (s2_reg.pos[BITPOS_W-1:3] >= s2_reg.wt);
    assign since    = {1'b0, s2_reg.pos} - {1'b0, s2_reg.mark};

    always_comb
    begin
        res.value   = s2_reg.read_en ? extract[VALUE_W-1:0] : '0;
        res.ok      = s2_reg.ok;
        res.overrun = at_end;
        if (since[BITPOS_W])
            res.bits_since_mark = '0;
        else if (since[BITPOS_W-1:CNT_W] != '0)
            res.bits_since_mark = '1;
        else
            res.bits_since_mark = since[CNT_W-1:0];
    end

    assign res_valid = s2_valid_reg;

endmodule

>>> hw/rtl/brr_resq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_resq
// Result queue between the executor and the result port.
// ----------------------------------------------------------------------------
module brr_resq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_valid,
    input  brr_pkg::brr_out_t              wr_data,
    output logic [brr_pkg::RESQ_LVL_W-1:0] level,
    output logic                           empty,
    input  logic                           pop,
    output brr_pkg::brr_out_t              result
);
    import brr_pkg::*;

    brr_out_t              q_mem_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [RESQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [RESQ_LVL_W-1:0] count_reg, count_next;
    logic                  do_pop;

    assign empty  = (count_reg == '0);
    assign level  = count_reg;
    assign result = q_mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_valid ? RESQ_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? RESQ_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_valid && !do_pop)
            count_next = RESQ_LVL_W'(count_reg + 1'b1);
        else if (do_pop && !wr_valid)
            count_next = RESQ_LVL_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
            q_mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> tb/sv/brr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_tb_pkg
// Scoreboard for the bit reservoir reader: tracks the reservoir, read position
// and mark for every accepted command word and checks each result word.
// ----------------------------------------------------------------------------
package brr_tb_pkg;

    import brr_pkg::*;

    class reservoir_scoreboard;

        logic [BYTE_W-1:0]   ring [STORE_DEPTH];
        logic [POS_W-1:0]    write_total;
        logic [POS_W-1:0]    rd_byte;
        logic [2:0]          rd_bit;
        logic [BITPOS_W-1:0] mark;
        bit                  wrapped;
        brr_out_t            pending_results [$];

        int errors    = 0;
        int checked   = 0;
        int overruns  = 0;
        int too_long  = 0;
        int wraps     = 0;
        int per_cmd [8];

        function new();
            foreach (ring[i])
                ring[i] = '0;
            foreach (per_cmd[i])
                per_cmd[i] = 0;
            write_total = '0;
            rd_byte     = '0;
            rd_bit      = '0;
            mark        = '0;
            wrapped     = 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // zero past the write end, more than a ring behind it, or before 0
        function logic [BYTE_W-1:0] byte_at(logic [POS_W-1:0] p);
            logic [POS_W-1:0] d;
            bit               live;
            d = write_total - p;
            if (wrapped)
                live = (d != 0) && (d <= STORE_DEPTH);
            else
                live = (p < write_total) && (d <= STORE_DEPTH);
            return live ? ring[p[STORE_AW-1:0]] : '0;
        endfunction

        function logic [BITPOS_W-1:0] bit_pos();
            return {rd_byte, rd_bit};
        endfunction

        function void move_to(logic [BITPOS_W-1:0] p);
            {rd_byte, rd_bit} = p;
        endfunction

        function logic [VALUE_W-1:0] window_bits(int n);
            logic [WORD_W-1:0] w;
            if (n == 0)
                return '0;
            w = {byte_at(rd_byte), byte_at(rd_byte + 16'd1),
                 byte_at(rd_byte + 16'd2), byte_at(rd_byte + 16'd3)};
            w = w << rd_bit;
            return VALUE_W'(w >> (WORD_W - n));
        endfunction

        // once the count has wrapped, anything half the space away counts as past the end
        function bit at_end();
            logic [POS_W-1:0] d;
            d = write_total - rd_byte;
            if (!wrapped)
                return rd_byte >= write_total;
            return (d == 0) || (d >= 16'h8000);
        endfunction

        function void note_word(brr_in_t w);
            brr_out_t r;
            int       since;
            r    = '0;
            r.ok = 1'b1;
            per_cmd[w.cmd]++;
            case (w.cmd)
                CMD_CLEAR:
                begin
                    write_total = '0;
                    rd_byte     = '0;
                    rd_bit      = '0;
                    wrapped     = 1'b0;
                end
                CMD_APPEND:
                begin
                    ring[write_total[STORE_AW-1:0]] = w.data_byte;
                    write_total++;
                    if (write_total == 0)
                    begin
                        wrapped = 1'b1;
                        wraps++;
                    end
                end
                CMD_BEGIN:
                begin
                    if (!wrapped && (w.back_offset > write_total))
                        r.ok = 1'b0;
                    else
                    begin
                        rd_byte = write_total - w.back_offset;
                        rd_bit  = '0;
                    end
                end
                CMD_GET, CMD_PEEK:
                begin
                    if (w.bit_count > MAX_READ_BITS)
                    begin
                        r.ok = 1'b0;
                        too_long++;
                    end
                    else
                    begin
                        r.value = window_bits(w.bit_count);
                        if (w.cmd == CMD_GET)
                            move_to(bit_pos() + w.bit_count);
                    end
                end
                CMD_SKIP:
                    move_to(bit_pos() + w.bit_count);
                CMD_MARK:
                    mark = bit_pos();
                default:
                    move_to(mark + w.bit_count);
            endcase
            since = int'(bit_pos()) - int'(mark);
            if (since < 0)
                since = 0;
            if (since > 32767)
                since = 32767;
            r.overrun         = at_end();
            r.bits_since_mark = since[CNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            // keep the log short when everything goes wrong at once
            if (errors <= 50)
                $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                         what, checked, got, want);
        endtask

        task check_word(brr_out_t got);
            brr_out_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result word", got.value, 0);
                return;
            end
            want = pending_results.pop_front();
            if (want.overrun)
                overruns++;
            if (got.value !== want.value)
                report_mismatch("value", got.value, want.value);
            if (got.ok !== want.ok)
                report_mismatch("ok", got.ok, want.ok);
            if (got.overrun !== want.overrun)
                report_mismatch("overrun", got.overrun, want.overrun);
            if (got.bits_since_mark !== want.bits_since_mark)
                report_mismatch("bits_since_mark", got.bits_since_mark,
                                want.bits_since_mark);
        endtask

    endclass

endpackage

>>> tb/sv/bit_reservoir_reader_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_reservoir_reader_tb
// Drives command words into the bit reservoir reader and checks every result.
// A directed run covers the edge cases, then random frames (appends, a frame
// start, a burst of reads) mixed with noise, a quiet run of back-to-back
// appends, and more random frames over the longer reservoir. Both the push and
// the pop side idle at random.
// ----------------------------------------------------------------------------
module bit_reservoir_reader_tb;

    import brr_pkg::*;
    import brr_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    logic     empty;
    logic     pop;
    brr_in_t  item;
    brr_out_t result;

    bit  quiet;
    int  sent;
    int  idle_cycles;
    reservoir_scoreboard sb;

    bit_reservoir_reader u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input logic [2:0] c, input int data, input int cnt, input int back);
        brr_in_t w;
        int      gap;
        w.cmd         = c;
        w.data_byte   = data[BYTE_W-1:0];
        w.bit_count   = cnt[CNT_W-1:0];
        w.back_offset = back[BACK_W-1:0];
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full !== 1'b0);
        sb.note_word(w);
        sent++;
        @(negedge clk);
    endtask

    // hold the sender off until every outstanding result word has been popped
    task automatic drain_results();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic frame_run();
        int k;
        int avail;
        int near;
        int back;
        int r;
        k = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 200);
        repeat (k)
            issue(CMD_APPEND, $urandom, $urandom, $urandom);
        if (sb.wrapped || sb.write_total > 4095)
            avail = 4095;
        else
            avail = int'(sb.write_total);
        near = (k + 8 < avail) ? k + 8 : avail;
        back = ($urandom_range(0, 9) < 8) ? $urandom_range(0, near) : $urandom_range(0, avail);
        issue(CMD_BEGIN, $urandom, $urandom, back);
        if ($urandom_range(0, 1) == 0)
            issue(CMD_MARK, $urandom, $urandom, $urandom);
        repeat ($urandom_range(2, 12))
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                issue(CMD_GET, $urandom, $urandom_range(0, MAX_READ_BITS), $urandom);
            else if (r < 65)
                issue(CMD_PEEK, $urandom, $urandom_range(0, MAX_READ_BITS), $urandom);
            else if (r < 78)
                issue(CMD_SKIP, $urandom, $urandom_range(0, 40), $urandom);
            else if (r < 86)
                issue(CMD_MARK, $urandom, $urandom, $urandom);
            else if (r < 94)
                issue(CMD_SEEK, $urandom, $urandom_range(0, 64), $urandom);
            else
                issue($urandom_range(0, 1) ? CMD_GET : CMD_PEEK, $urandom,
                      $urandom_range(MAX_READ_BITS + 1, 40), $urandom);
        end
    endtask

    task automatic noise_burst();
        logic [2:0] c;
        int         cnt;
        if ($urandom_range(0, 99) < 6)
        begin
            // long run of big skips: far past the end, and round the bit position space
            repeat ($urandom_range(4, 20))
                issue(CMD_SKIP, $urandom, $urandom_range(30000, 32767), $urandom);
            issue(CMD_GET, $urandom, $urandom_range(0, MAX_READ_BITS), $urandom);
        end
        else
        begin
            c = 3'($urandom_range(0, 7));
            if (c == CMD_CLEAR && $urandom_range(0, 4) != 0)
                c = 3'($urandom_range(1, 7));
            cnt = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 30);
            issue(c, $urandom, cnt, $urandom);
        end
    endtask

    task automatic random_phase(input int words);
        int start;
        start = sent;
        while (sent - start < words)
        begin
            if ($urandom_range(0, 99) < 15)
                quiet = !quiet;
            if ($urandom_range(0, 99) < 65)
                frame_run();
            else
                noise_burst();
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
        quiet = 1'b0;
    endtask

    // result side
    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty !== 1'b0);
            sb.check_word(result);
            @(negedge clk);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && full === 1'b0) || (pop && empty === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        quiet = 1'b0;
        sent  = 0;
        sb    = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty reservoir, first frame, field extremes, reads past the end
        issue(CMD_GET,    0, 8, 0);
        issue(CMD_BEGIN,  0, 0, 1);
        issue(CMD_APPEND, 8'hFF, 0, 0);
        issue(CMD_APPEND, 8'h00, 0, 0);
        issue(CMD_APPEND, 8'hA5, 0, 0);
        issue(CMD_APPEND, 8'h5A, 0, 0);
        issue(CMD_APPEND, 8'h80, 0, 0);
        issue(CMD_APPEND, 8'h01, 0, 0);
        issue(CMD_BEGIN,  0, 0, 6);
        issue(CMD_PEEK,   0, 0, 0);
        issue(CMD_PEEK,   0, MAX_READ_BITS, 0);
        issue(CMD_GET,    0, MAX_READ_BITS + 1, 0);
        issue(CMD_GET,    0, MAX_READ_BITS, 0);
        issue(CMD_MARK,   0, 0, 0);
        issue(CMD_GET,    0, 3, 0);
        issue(CMD_SKIP,   0, 5, 0);
        issue(CMD_SEEK,   0, 32767, 4095);
        issue(CMD_SEEK,   0, 0, 0);
        issue(CMD_GET,    0, 7, 0);
        issue(CMD_GET,    0, 24, 0);
        issue(CMD_BEGIN,  0, 0, 4095);
        issue(CMD_BEGIN,  0, 0, 0);
        issue(CMD_SKIP,   0, 32767, 0);
        issue(CMD_CLEAR,  8'hFF, 32767, 4095);
        issue(CMD_APPEND, 8'h3C, 0, 0);
        drain_results();

        random_phase(600);
        drain_results();

        // back-to-back appends build a longer reservoir for the frames that follow
        quiet = 1'b1;
        repeat (120)
            issue(CMD_APPEND, $urandom, $urandom, $urandom);
        quiet = 1'b0;

        random_phase(680);

        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d words: clear %0d, append %0d, begin %0d, get %0d, peek %0d,",
                 sent, sb.per_cmd[CMD_CLEAR], sb.per_cmd[CMD_APPEND],
                 sb.per_cmd[CMD_BEGIN], sb.per_cmd[CMD_GET], sb.per_cmd[CMD_PEEK]);
        $display("  skip %0d, mark %0d, seek %0d; %0d results checked, %0d at the end,",
                 sb.per_cmd[CMD_SKIP], sb.per_cmd[CMD_MARK], sb.per_cmd[CMD_SEEK],
                 sb.checked, sb.overruns);
        $display("  %0d over-long reads, write count wrapped %0d times",
                 sb.too_long, sb.wraps);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/brr_pkg.sv
hw/rtl/brr_front.sv
hw/rtl/brr_exec.sv
hw/rtl/brr_resq.sv
hw/rtl/bit_reservoir_reader.sv
tb/sv/brr_tb_pkg.sv
tb/sv/bit_reservoir_reader_tb.sv
